[hw/rtl/ffa_pkg.sv]
// ----------------------------------------------------------------------------
// ffa_pkg
// Shared types and constants of the first-fit free-list allocator.
// ----------------------------------------------------------------------------
package ffa_pkg;

  localparam int HEAP_UNITS   = 4096;
  localparam int UNIT_BYTES   = 16;
  localparam int PAGE_BYTES   = 4096;
  localparam int ADDR_W       = 12;
  localparam int SIZE_W       = 13;
  localparam int UNIT_SHIFT   = $clog2(UNIT_BYTES);
  localparam int PAGE_UNITS   = PAGE_BYTES / UNIT_BYTES;
  localparam int PAGE_SHIFT   = $clog2(PAGE_UNITS);
  localparam int WALK_LIMIT   = 2 * HEAP_UNITS + 4;
  localparam int STEP_W       = $clog2(WALK_LIMIT + 2);
  localparam int LIMIT_RESET  = 4096;

  localparam logic OPER_ALLOC = 1'b0;
  localparam logic OPER_FREE  = 1'b1;

  // Controller states; the datapath command carries the same codes
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_T_START,
    ST_T_FIRST,
    ST_T_CHECK,
    ST_T_SPLIT,
    ST_PF_START,
    ST_PF_WALK,
    ST_PF_RDB,
    ST_PF_RDN,
    ST_PF_WP,
    ST_G_RD,
    ST_G_NEXT,
    ST_DONE
  } ffa_state_t;

  typedef struct packed {
    ffa_state_t step;     // work step the datapath performs this cycle
    logic       load;     // take a new transaction
    logic       out_load; // move the result into the output register
  } ffa_cmd_t;

  typedef struct packed {
    logic is_free;
    logic null_free;
    logic fit;
    logic exact;
    logic at_rover;
    logic grow_ok;
    logic t_over;
    logic f_over;
    logic found;
    logic brk_ok;
  } ffa_status_t;

endpackage

[hw/rtl/first_fit_free_list_allocator_core.sv]
// ----------------------------------------------------------------------------
// first_fit_free_list_allocator_core
// First-fit heap allocator over 4096 units of 16 bytes with a free list.
// ----------------------------------------------------------------------------
// Input stream s_*: s_tuser is the operation (0 allocate, 1 free); s_tdata
// carries the byte count of an allocate and the user unit index to free.
// Output stream m_*: one transaction per input: the granted user unit index
// (0 for a free or a failure) and, in m_tuser, the out-of-memory flag.
// cfg_we/cfg_wdata set the highest unit the break pointer may reach.
// One transaction is in work at a time. An allocate walks the free list,
// reading one header per cycle from the header store; heap growth adds
// the ordered-insert walk. A free walks the list in the same way; a null
// free skips the walk. The walk length follows fragmentation.
// Reset empties the heap: the list holds only the sentinel, break is 1 and
// the limit is 4096; no clearing pass is needed. A finished result waits in
// the output register while the next transaction is accepted; a further
// result holds the sequencer until the receiver takes the first.
// ----------------------------------------------------------------------------
module first_fit_free_list_allocator_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [15:0] request_bytes, [27:16] block_address
  input  logic        s_tuser,   // operation
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [11:0] granted_address
  output logic        m_tuser,   // out_of_memory
  input  logic        cfg_we,
  input  logic [12:0] cfg_wdata  // heap_limit_units
);
  import ffa_pkg::*;

  ffa_cmd_t          cmd;
  ffa_status_t       st;
  logic [ADDR_W-1:0] granted;

  ffa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .st       (st),
    .cmd      (cmd)
  );

  ffa_datapath u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .st              (st),
    .oper            (s_tuser),
    .request_bytes   (s_tdata[15:0]),
    .block_address   (s_tdata[27:16]),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .granted_address (granted),
    .out_of_memory   (m_tuser)
  );

  assign m_tdata = {4'b0, granted};

  // One transaction in work at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted while a transaction is in work");

  // Break pointer stays inside the heap
  a_brk_range: assert property (@(posedge clk) disable iff (rst) st.brk_ok)
    else $error("break pointer beyond heap");

  // A failed allocate grants nothing
  a_oom_null: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata == '0))
    else $error("out of memory with nonzero address");

endmodule

[hw/rtl/ffa_datapath.sv]
// ----------------------------------------------------------------------------
// ffa_datapath
// Header memories, list pointers, walk counters and result registers.
// ----------------------------------------------------------------------------
module ffa_datapath (
  input  logic                      clk,
  input  logic                      rst,
  input  ffa_pkg::ffa_cmd_t         cmd,
  output ffa_pkg::ffa_status_t      st,
  input  logic                      oper,
  input  logic [15:0]               request_bytes,
  input  logic [ffa_pkg::ADDR_W-1:0] block_address,
  input  logic                      cfg_we,
  input  logic [ffa_pkg::SIZE_W-1:0] cfg_wdata,
  output logic [ffa_pkg::ADDR_W-1:0] granted_address,
  output logic                      out_of_memory
);
  import ffa_pkg::*;

  // Header store; entry 0 (sentinel) lives in flops so that it resets
  logic [ADDR_W-1:0] mem_next [HEAP_UNITS];
  logic [SIZE_W-1:0] mem_size [HEAP_UNITS];
  logic [ADDR_W-1:0] s0_next, mq_next, s0q_next, q_next;
  logic [SIZE_W-1:0] s0_size, mq_size, s0q_size, q_size;
  logic              rd_zero;

  logic [ADDR_W-1:0] rd_addr, wr_addr, wd_next;
  logic [SIZE_W-1:0] wd_size;
  logic              we_next, we_size;

  // Working registers
  logic [ADDR_W-1:0] rover, p, prev, bp, pn;
  logic [SIZE_W-1:0] brk, limit, nunits, psz, bsz;
  logic [STEP_W-1:0] tsteps, fsteps;
  logic [ADDR_W-1:0] res_addr;
  logic              res_oom;

  logic [SIZE_W:0]   grow_units, brk_sum, req_units;
  logic [SIZE_W-1:0] lim_eff, newsz, merged_hi, nbsz;
  logic [ADDR_W-1:0] nbnx;
  logic              merge_hi, merge_lo;

  // Write and read the header store
  always_ff @(posedge clk) begin
    if (we_next) mem_next[wr_addr] <= wd_next;
    if (we_size) mem_size[wr_addr] <= wd_size;
    mq_next  <= mem_next[rd_addr];
    mq_size  <= mem_size[rd_addr];
    s0q_next <= s0_next;
    s0q_size <= s0_size;
    rd_zero  <= (rd_addr == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_next <= '0;
      s0_size <= '0;
    end else if (wr_addr == '0) begin
      if (we_next) s0_next <= wd_next;
      if (we_size) s0_size <= wd_size;
    end
  end

  assign q_next = rd_zero ? s0q_next : mq_next;
  assign q_size = rd_zero ? s0q_size : mq_size;

  // Size arithmetic
  assign req_units  = ((SIZE_W+1)'({1'b0, request_bytes} + 17'(UNIT_BYTES - 1)
                        >> UNIT_SHIFT)) + 1'b1;
  assign grow_units = ((({1'b0, nunits} + (SIZE_W+1)'(PAGE_UNITS - 1)) >> PAGE_SHIFT)
                        << PAGE_SHIFT);
  assign brk_sum    = {1'b0, brk} + grow_units;
  assign lim_eff    = (limit > SIZE_W'(HEAP_UNITS)) ? SIZE_W'(HEAP_UNITS) : limit;
  assign newsz      = q_size - nunits;
  assign merged_hi  = bsz + q_size;
  assign merge_hi   = ({2'b0, bp} + {1'b0, bsz}) == {2'b0, pn};
  assign merge_lo   = ({2'b0, p} + {1'b0, psz}) == {2'b0, bp};
  assign nbsz       = merge_hi ? merged_hi : bsz;
  assign nbnx       = merge_hi ? q_next : pn;

  // Status toward the controller
  always_comb begin
    st.is_free   = (oper == OPER_FREE);
    st.null_free = (block_address == '0);
    st.fit       = (q_size >= nunits);
    st.exact     = (q_size == nunits);
    st.at_rover  = (p == rover);
    st.grow_ok   = (brk_sum <= {1'b0, lim_eff});
    st.t_over    = ((tsteps + 1'b1) > STEP_W'(WALK_LIMIT));
    st.f_over    = ((fsteps + 1'b1) > STEP_W'(WALK_LIMIT));
    st.found     = ((bp > p) && (bp < q_next)) ||
                   ((p >= q_next) && ((bp > p) || (bp < q_next)));
    st.brk_ok    = (brk <= SIZE_W'(HEAP_UNITS));
  end

  // Memory addresses and write data per step
  always_comb begin
    rd_addr = p;
    wr_addr = p;
    wd_next = '0;
    wd_size = '0;
    we_next = 1'b0;
    we_size = 1'b0;
    case (cmd.step)
      ST_T_START, ST_PF_START, ST_G_RD: rd_addr = rover;
      ST_T_FIRST, ST_G_NEXT: rd_addr = q_next;
      ST_T_CHECK: begin
        rd_addr = q_next;
        if (st.fit && st.exact) begin
          wr_addr = prev;
          wd_next = q_next;
          we_next = 1'b1;
        end else if (st.fit) begin
          wd_size = newsz;
          we_size = 1'b1;
        end else if (st.at_rover && st.grow_ok) begin
          wr_addr = brk[ADDR_W-1:0];
          wd_size = grow_units[SIZE_W-1:0];
          we_size = 1'b1;
        end
      end
      ST_T_SPLIT: begin
        wr_addr = pn;
        wd_size = nunits;
        we_size = 1'b1;
      end
      ST_PF_WALK: rd_addr = st.found ? bp : q_next;
      ST_PF_RDB:  rd_addr = pn;
      ST_PF_RDN: begin
        wr_addr = bp;
        wd_next = nbnx;
        wd_size = merged_hi;
        we_next = 1'b1;
        we_size = merge_hi;
      end
      ST_PF_WP: begin
        wd_next = merge_lo ? pn : bp;
        wd_size = psz + bsz;
        we_next = 1'b1;
        we_size = merge_lo;
      end
      default: ;
    endcase
  end

  // Control registers of the heap
  always_ff @(posedge clk) begin
    if (rst) begin
      rover <= '0;
      brk   <= SIZE_W'(1);
      limit <= SIZE_W'(LIMIT_RESET);
    end else begin
      if (cfg_we) limit <= cfg_wdata;
      case (cmd.step)
        ST_T_CHECK: begin
          if (st.fit) rover <= prev;
          else if (st.at_rover && st.grow_ok) brk <= brk_sum[SIZE_W-1:0];
        end
        ST_PF_WP: rover <= p;
        default: ;
      endcase
    end
  end

  // Walk registers and results
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      nunits   <= req_units[SIZE_W-1:0];
      bp       <= block_address - 1'b1;
      res_addr <= '0;
      res_oom  <= 1'b0;
    end
    if (cmd.out_load) begin
      granted_address <= res_addr;
      out_of_memory   <= res_oom;
    end
    case (cmd.step)
      ST_T_START: begin
        prev   <= rover;
        tsteps <= '0;
      end
      ST_T_FIRST: p <= q_next;
      ST_T_CHECK: begin
        if (st.fit && st.exact) begin
          res_addr <= p + 1'b1;
        end else if (st.fit) begin
          pn <= p + newsz[ADDR_W-1:0];
        end else if (st.at_rover) begin
          if (st.grow_ok) bp <= brk[ADDR_W-1:0];
          else res_oom <= 1'b1;
        end else begin
          prev   <= p;
          p      <= q_next;
          tsteps <= tsteps + 1'b1;
          if (st.t_over) res_oom <= 1'b1;
        end
      end
      ST_T_SPLIT: res_addr <= pn + 1'b1;
      ST_PF_START: begin
        p      <= rover;
        fsteps <= '0;
      end
      ST_PF_WALK: begin
        if (st.found) begin
          psz <= q_size;
          pn  <= q_next;
        end else begin
          p      <= q_next;
          fsteps <= fsteps + 1'b1;
        end
      end
      ST_PF_RDB: bsz <= q_size;
      ST_PF_RDN: begin
        bsz <= nbsz;
        pn  <= nbnx;
      end
      ST_G_RD: prev <= rover;
      ST_G_NEXT: begin
        p      <= q_next;
        tsteps <= tsteps + 1'b1;
        if (st.t_over) res_oom <= 1'b1;
      end
      default: ;
    endcase
  end

endmodule

[hw/rtl/ffa_ctrl.sv]
// ----------------------------------------------------------------------------
// ffa_ctrl
// Sequencer for allocate and free transactions and the output valid flag.
// ----------------------------------------------------------------------------
module ffa_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  input  ffa_pkg::ffa_status_t st,
  output ffa_pkg::ffa_cmd_t    cmd
);
  import ffa_pkg::*;

  ffa_state_t state, state_next;
  logic       from_grow, from_grow_next;
  ffa_state_t pf_ret;

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      from_grow <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      state     <= state_next;
      from_grow <= from_grow_next;
      if (cmd.out_load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  assign pf_ret = from_grow ? ST_G_RD : ST_DONE;

  // Advance the sequence
  always_comb begin
    state_next     = state;
    from_grow_next = from_grow;
    s_tready       = 1'b0;
    cmd.step       = state;
    cmd.load       = 1'b0;
    cmd.out_load   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready       = 1'b1;
        from_grow_next = 1'b0;
        if (s_tvalid) begin
          cmd.load = 1'b1;
          if (st.is_free) state_next = st.null_free ? ST_DONE : ST_PF_START;
          else state_next = ST_T_START;
        end
      end
      ST_T_START: state_next = ST_T_FIRST;
      ST_T_FIRST: state_next = ST_T_CHECK;
      ST_T_CHECK: begin
        if (st.fit) begin
          state_next = st.exact ? ST_DONE : ST_T_SPLIT;
        end else if (st.at_rover) begin
          if (st.grow_ok) begin
            state_next     = ST_PF_START;
            from_grow_next = 1'b1;
          end else begin
            state_next = ST_DONE;
          end
        end else if (st.t_over) begin
          state_next = ST_DONE;
        end
      end
      ST_T_SPLIT:  state_next = ST_DONE;
      ST_PF_START: state_next = ST_PF_WALK;
      ST_PF_WALK: begin
        if (st.found) state_next = ST_PF_RDB;
        else if (st.f_over) state_next = pf_ret;
      end
      ST_PF_RDB: state_next = ST_PF_RDN;
      ST_PF_RDN: state_next = ST_PF_WP;
      ST_PF_WP:  state_next = pf_ret;
      ST_G_RD:   state_next = ST_G_NEXT;
      ST_G_NEXT: state_next = st.t_over ? ST_DONE : ST_T_CHECK;
      ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

[sim/tb_first_fit_free_list_allocator_core.sv]
// ----------------------------------------------------------------------------
// tb_first_fit_free_list_allocator_core
// Self-checking bench for the first-fit free-list heap allocator.
// ----------------------------------------------------------------------------
// Allocate and free transactions go into the input stream. Every accepted
// transaction is run through a local free-list predictor, and each output
// transaction is compared with the oldest prediction. Frees only name
// blocks that an earlier allocate granted, or null. The heap limit register
// is changed between phases while the core is idle. Both stream sides idle
// in random bursts. One long receiver stall fills the core.
// ----------------------------------------------------------------------------
module tb_first_fit_free_list_allocator_core;
  timeunit 1ns;
  timeprecision 1ps;
  import ffa_pkg::*;

  typedef struct {
    logic        op;
    logic [15:0] nbytes;
    logic [11:0] addr;
    bit          pick;    // free a block granted earlier
    bit          typed;   // expected result given in the row
    logic [11:0] exp_addr;
    logic        exp_oom;
  } heap_req_t;

  typedef struct {
    logic [11:0] addr;
    logic        oom;
  } heap_rsp_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;   // [15:0] request_bytes, [27:16] block_address
  logic        s_tuser;   // operation
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;   // [11:0] granted_address
  logic        m_tuser;   // out_of_memory
  logic        cfg_we;
  logic [12:0] cfg_wdata; // heap_limit_units

  first_fit_free_list_allocator_core dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Local copy of the heap
  logic [11:0] hdr_next[HEAP_UNITS];
  logic [12:0] hdr_size[HEAP_UNITS];
  int unsigned rover_ix;
  int unsigned break_ix;
  int unsigned limit_units;

  heap_req_t   pending_q[$];
  heap_rsp_t   grant_q[$];
  logic [11:0] live_q[$];
  int          errors = 0;
  bit          quiet = 0;
  bit          hold_req = 0;

  task automatic report_mismatch(string what, int got, int exp);
    $display("MISMATCH %s: got %0d expected %0d", what, got, exp);
    errors++;
  endtask

  // Ordered insert with merge on both sides
  function automatic bit insert_free(int unsigned bp_in);
    int unsigned p, nx, pn, bsz, bp, steps;
    bp = bp_in % HEAP_UNITS;
    p = rover_ix;
    steps = 0;
    while (1) begin
      nx = hdr_next[p];
      if (bp > p && bp < nx) break;
      if (p >= nx && (bp > p || bp < nx)) break;
      p = nx;
      steps++;
      if (steps > WALK_LIMIT) return 0;
    end
    bsz = hdr_size[bp];
    pn = hdr_next[p];
    if (bp + bsz == pn) begin
      hdr_size[bp] = 13'(bsz + hdr_size[pn]);
      hdr_next[bp] = hdr_next[pn];
    end else begin
      hdr_next[bp] = 12'(pn);
    end
    if (p + hdr_size[p] == bp) begin
      hdr_size[p] = 13'(int'(hdr_size[p]) + int'(hdr_size[bp]));
      hdr_next[p] = hdr_next[bp];
    end else begin
      hdr_next[p] = 12'(bp);
    end
    rover_ix = p;
    return 1;
  endfunction

  function automatic bit grow_heap(int unsigned nunits);
    int unsigned lim, g, hdr;
    lim = (limit_units > HEAP_UNITS) ? HEAP_UNITS : limit_units;
    g = ((nunits + PAGE_UNITS - 1) / PAGE_UNITS) * PAGE_UNITS;
    if (break_ix + g > lim) return 0;
    hdr = break_ix % HEAP_UNITS;
    hdr_size[hdr] = 13'(g);
    break_ix += g;
    void'(insert_free(hdr));
    return 1;
  endfunction

  // First-fit search from the rover; returns header index + 1 or 0
  function automatic int unsigned alloc_block(int unsigned nbytes);
    int unsigned n, prev, p, steps;
    n = (nbytes + UNIT_BYTES - 1) / UNIT_BYTES + 1;
    prev = rover_ix;
    p = hdr_next[prev];
    steps = 0;
    while (1) begin
      if (hdr_size[p] >= n) begin
        if (hdr_size[p] == n) begin
          hdr_next[prev] = hdr_next[p];
        end else begin
          hdr_size[p] = 13'(int'(hdr_size[p]) - int'(n));
          p = (p + hdr_size[p]) % HEAP_UNITS;
          hdr_size[p] = 13'(n);
        end
        rover_ix = prev;
        return p + 1;
      end
      if (p == rover_ix) begin
        if (!grow_heap(n)) return 0;
        p = rover_ix;
      end
      prev = p;
      p = hdr_next[p];
      steps++;
      if (steps > WALK_LIMIT) return 0;
    end
  endfunction

  // Predict on every accepted transaction, check every delivered one
  always @(posedge clk) begin
    heap_req_t   rq;
    heap_rsp_t   rs;
    heap_rsp_t   ex;
    int unsigned got;
    if (!rst) begin
      if (cfg_we) limit_units = cfg_wdata;
      if (s_tvalid && s_tready) begin
        rq = pending_q.pop_front();
        if (rq.op == OPER_FREE) begin
          if (rq.addr != 0) void'(insert_free(rq.addr - 1));
          rs.addr = '0;
          rs.oom = 1'b0;
        end else begin
          got = alloc_block(rq.nbytes);
          rs.addr = 12'(got);
          rs.oom = (got == 0);
          if (rs.addr != 0) live_q.push_back(rs.addr);
        end
        if (rq.typed) begin
          rs.addr = rq.exp_addr;
          rs.oom = rq.exp_oom;
        end
        grant_q.push_back(rs);
      end
      if (m_tvalid && m_tready) begin
        if (grant_q.size() == 0) begin
          report_mismatch("unexpected transaction, granted_address", m_tdata[11:0], 0);
        end else begin
          ex = grant_q.pop_front();
          if (m_tdata[11:0] !== ex.addr)
            report_mismatch("granted_address", m_tdata[11:0], ex.addr);
          if (m_tuser !== ex.oom)
            report_mismatch("out_of_memory", m_tuser, ex.oom);
        end
      end
    end
  end

  // Receiver: random stalls, one long hold-off on request
  initial begin
    m_tready <= 1'b0;
    forever begin
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_req = 0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  task automatic send_req(heap_req_t rq);
    logic [11:0] a;
    int          k;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    a = rq.addr;
    if (rq.pick) begin
      if (live_q.size() == 0) begin
        rq.op = OPER_ALLOC;
      end else begin
        k = $urandom_range(0, live_q.size() - 1);
        a = live_q[k];
        live_q.delete(k);
      end
    end else if (rq.op == OPER_FREE) begin
      // Drop a directly named block from the live list
      for (k = 0; k < live_q.size(); k++) begin
        if (live_q[k] == a) begin
          live_q.delete(k);
          break;
        end
      end
    end
    if (rq.op == OPER_FREE) rq.addr = a;
    pending_q.push_back(rq);
    s_tvalid <= 1'b1;
    s_tuser <= rq.op;
    s_tdata <= {4'b0, a, rq.nbytes};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic send_random(int count, int alloc_pct);
    heap_req_t rq;
    int        r;
    repeat (count) begin
      rq = '{default: '0};
      rq.addr = 12'($urandom);
      r = $urandom_range(0, 99);
      if (r < 70) rq.nbytes = 16'($urandom_range(0, 512));
      else if (r < 92) rq.nbytes = 16'($urandom_range(0, 4095));
      else rq.nbytes = 16'($urandom);
      if ($urandom_range(0, 99) >= alloc_pct) begin
        rq.op = OPER_FREE;
        if ($urandom_range(0, 19) == 0) rq.addr = '0;
        else rq.pick = 1;
      end else begin
        rq.op = OPER_ALLOC;
      end
      send_req(rq);
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (grant_q.size() != 0 || pending_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_limit(logic [12:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // op, bytes, addr, pick, typed, exp_addr, exp_oom
  heap_req_t dir_tbl[] = '{
    '{OPER_ALLOC, 16'd0,     12'd0,   0, 1, 12'd257, 1'b0},
    '{OPER_ALLOC, 16'd1,     12'd0,   0, 0, 12'd0,   1'b0},
    '{OPER_ALLOC, 16'd16,    12'd0,   0, 0, 12'd0,   1'b0},
    '{OPER_ALLOC, 16'd17,    12'd0,   0, 0, 12'd0,   1'b0},
    '{OPER_ALLOC, 16'd4079,  12'd0,   0, 0, 12'd0,   1'b0},
    '{OPER_ALLOC, 16'd4080,  12'd0,   0, 0, 12'd0,   1'b0},
    '{OPER_ALLOC, 16'd4081,  12'd0,   0, 0, 12'd0,   1'b0},
    '{OPER_FREE,  16'd0,     12'd257, 0, 1, 12'd0,   1'b0},
    '{OPER_FREE,  16'hFFFF,  12'd0,   0, 1, 12'd0,   1'b0},
    '{OPER_ALLOC, 16'hFFFF,  12'hFFF, 0, 1, 12'd0,   1'b1},
    '{OPER_ALLOC, 16'd65520, 12'd0,   0, 1, 12'd0,   1'b1},
    '{OPER_ALLOC, 16'd0,     12'd0,   0, 0, 12'd0,   1'b0},
    '{OPER_FREE,  16'd0,     12'd0,   1, 0, 12'd0,   1'b0},
    '{OPER_FREE,  16'd0,     12'd0,   1, 0, 12'd0,   1'b0},
    '{OPER_ALLOC, 16'd32768, 12'd0,   0, 0, 12'd0,   1'b0},
    '{OPER_FREE,  16'd0,     12'd0,   1, 0, 12'd0,   1'b0},
    '{OPER_ALLOC, 16'd2,     12'd0,   0, 0, 12'd0,   1'b0},
    '{OPER_FREE,  16'd0,     12'd0,   1, 0, 12'd0,   1'b0},
    '{OPER_FREE,  16'd0,     12'd0,   1, 0, 12'd0,   1'b0},
    '{OPER_ALLOC, 16'd300,   12'd0,   0, 0, 12'd0,   1'b0}
  };

  // Main sequence
  initial begin
    for (int i = 0; i < HEAP_UNITS; i++) begin
      hdr_next[i] = '0;
      hdr_size[i] = '0;
    end
    rover_ix = 0;
    break_ix = 1;
    limit_units = LIMIT_RESET;
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    s_tuser <= OPER_ALLOC;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed rows
    foreach (dir_tbl[i]) send_req(dir_tbl[i]);
    drain();

    // Fill the heap toward its top
    write_limit(13'd4096);
    send_random(200, 70);
    drain();

    // No growth allowed: only existing free space serves
    write_limit(13'd1);
    send_random(80, 50);
    drain();

    // Limit above the heap size; long receiver stall first
    write_limit(13'h1FFF);
    hold_req = 1;
    send_random(150, 45);
    drain();

    // Small limit, then the full heap with no idling
    write_limit(13'd600);
    send_random(40, 55);
    drain();
    write_limit(13'd4096);
    quiet = 1;
    send_random(80, 55);
    drain();

    if (errors == 0) begin
      $display("first_fit_free_list_allocator_core test passed");
    end else begin
      $display("first_fit_free_list_allocator_core test failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #50_000_000;
    $display("first_fit_free_list_allocator_core test failed");
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/ffa_pkg.sv
hw/rtl/ffa_datapath.sv
hw/rtl/ffa_ctrl.sv
hw/rtl/first_fit_free_list_allocator_core.sv
sim/tb_first_fit_free_list_allocator_core.sv
